>>> hw/rtl/spec_tlx_pkg.sv
// ----------------------------------------------------------------------------
// spec_tlx_pkg
// Shared types, token codes and byte classes of the token lexer.
// ----------------------------------------------------------------------------
package spec_tlx_pkg;

   // Default identifier buffer size; NAME_BYTES-1 characters are kept.
   localparam int NAME_BYTES_DEF = 32;

   // Token kinds as seen on the result channel.
   localparam logic [3:0] K_IDENT  = 4'd0;
   localparam logic [3:0] K_COLON  = 4'd1;
   localparam logic [3:0] K_ARROW  = 4'd2;
   localparam logic [3:0] K_EQ     = 4'd3;
   localparam logic [3:0] K_LPAREN = 4'd4;
   localparam logic [3:0] K_RPAREN = 4'd5;
   localparam logic [3:0] K_COMMA  = 4'd6;
   localparam logic [3:0] K_GT     = 4'd7;
   localparam logic [3:0] K_ERROR  = 4'd8;
   localparam logic [3:0] K_END    = 4'd9;

   // Source bytes with a meaning of their own.
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_UNDER   = 8'h5F;

   // One result item.
   typedef struct packed {
      logic [3:0] token_kind;
      logic [7:0] text_byte;
      logic [4:0] char_index;
      logic [4:0] ident_length;
      logic       token_last;
      logic       run_last;
   } res_type;

   function automatic logic is_ident_byte(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], CH_UNDER});
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF});
   endfunction

   // Kind of a single-byte token; anything unknown is an error token.
   function automatic logic [3:0] punct_kind(input logic [7:0] c);
      logic [3:0] k;
      case (c)
         CH_COLON:  k = K_COLON;
         CH_EQ:     k = K_EQ;
         CH_LPAREN: k = K_LPAREN;
         CH_RPAREN: k = K_RPAREN;
         CH_COMMA:  k = K_COMMA;
         CH_GT:     k = K_GT;
         default:   k = K_ERROR;
      endcase
      return k;
   endfunction

endpackage

>>> hw/rtl/spec_tlx_mem.sv
// ----------------------------------------------------------------------------
// spec_tlx_mem
// Identifier text buffer: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spec_tlx_mem #(
   parameter int DEPTH = 31,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/spec_tlx_seq.sv
// ----------------------------------------------------------------------------
// spec_tlx_seq
// Byte classifier, lexer mode state and result sequencer around the buffer.
// ----------------------------------------------------------------------------
module spec_tlx_seq #(
   parameter int NAME_BYTES = spec_tlx_pkg::NAME_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_byte,
   input  logic                  req_end,
   input  logic                  out_free,
   output logic                  res_valid,
   output spec_tlx_pkg::res_type res
);
   import spec_tlx_pkg::*;

   localparam int CAP = NAME_BYTES - 1;
   localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int CW  = $clog2(NAME_BYTES);
   localparam logic [CW-1:0] CAP_C = CW'(CAP);

   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_IDENT   = 2'd1;
   localparam logic [1:0] MODE_COMMENT = 2'd2;
   localparam logic [1:0] MODE_DASH    = 2'd3;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FLUSH = 2'd1;
   localparam logic [1:0] ST_ERR   = 2'd2;
   localparam logic [1:0] ST_TAIL  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   logic [CW-1:0] kept_ff, kept_in;
   logic [CW-1:0] flen_ff, flen_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rd_ok_ff, rd_ok_in;
   logic          tail_v_ff, tail_v_in;
   logic [3:0]    tail_k_ff, tail_k_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    rd_data;
   logic          accept, is_eoi;

   spec_tlx_mem #(
      .DEPTH (CAP),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign is_eoi    = req_end | (req_byte == CH_NUL);

   always_comb begin
      logic          do_flush, do_err, lex, last_char;
      logic [CW-1:0] idx_nx;
      do_flush  = 1'b0;
      do_err    = 1'b0;
      lex       = 1'b0;
      last_char = 1'b0;
      idx_nx    = idx_ff + 1'b1;

      state_in  = state_ff;
      mode_in   = mode_ff;
      kept_in   = kept_ff;
      flen_in   = flen_ff;
      idx_in    = idx_ff;
      rd_ok_in  = rd_ok_ff;
      tail_v_in = tail_v_ff;
      tail_k_in = tail_k_ff;
      wr_en     = 1'b0;
      wr_addr   = kept_ff[AW-1:0];
      rd_en     = 1'b0;
      rd_addr   = idx_ff[AW-1:0];
      res_valid = 1'b0;
      res       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tail_v_in = 1'b0;
               tail_k_in = K_END;
               if (is_eoi) begin
                  do_flush  = (mode_ff == MODE_IDENT);
                  do_err    = (mode_ff == MODE_DASH);
                  tail_v_in = 1'b1;
                  mode_in   = MODE_IDLE;
                  kept_in   = '0;
               end else begin
                  case (mode_ff)
                     MODE_COMMENT: begin
                        if (req_byte == CH_LF) begin
                           mode_in = MODE_IDLE;
                        end
                     end
                     MODE_IDENT: begin
                        if (is_ident_byte(req_byte)) begin
                           if (kept_ff < CAP_C) begin
                              wr_en   = 1'b1;
                              kept_in = kept_ff + 1'b1;
                           end
                        end else begin
                           do_flush = 1'b1;
                           mode_in  = MODE_IDLE;
                           kept_in  = '0;
                           lex      = 1'b1;
                        end
                     end
                     MODE_DASH: begin
                        mode_in = MODE_IDLE;
                        if (req_byte == CH_GT) begin
                           tail_v_in = 1'b1;
                           tail_k_in = K_ARROW;
                        end else begin
                           do_err = 1'b1;
                           lex    = 1'b1;
                        end
                     end
                     default: begin
                        lex = 1'b1;
                     end
                  endcase
                  if (lex) begin
                     if (is_space(req_byte)) begin
                        mode_in = MODE_IDLE;
                     end else if (req_byte == CH_PERCENT) begin
                        mode_in = MODE_COMMENT;
                     end else if (is_ident_byte(req_byte)) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        kept_in = CW'(1);
                        mode_in = MODE_IDENT;
                     end else if (req_byte == CH_DASH) begin
                        mode_in = MODE_DASH;
                     end else begin
                        tail_v_in = 1'b1;
                        tail_k_in = punct_kind(req_byte);
                     end
                  end
               end
               flen_in  = kept_ff;
               idx_in   = '0;
               rd_ok_in = 1'b0;
               if (do_flush) begin
                  state_in = ST_FLUSH;
               end else if (do_err) begin
                  state_in = ST_ERR;
               end else if (tail_v_in) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_FLUSH: begin
            if (!rd_ok_ff) begin
               rd_en    = 1'b1;
               rd_ok_in = 1'b1;
            end else if (out_free) begin
               last_char        = (idx_nx == flen_ff);
               res_valid        = 1'b1;
               res.token_kind   = K_IDENT;
               res.text_byte    = rd_data;
               res.char_index   = 5'(idx_ff);
               res.ident_length = 5'(flen_ff);
               res.token_last   = last_char;
               res.run_last     = last_char & ~tail_v_ff;
               if (last_char) begin
                  rd_ok_in = 1'b0;
                  state_in = tail_v_ff ? ST_TAIL : ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_nx[AW-1:0];
                  idx_in  = idx_nx;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               res_valid      = 1'b1;
               res.token_kind = K_ERROR;
               res.token_last = 1'b1;
               res.run_last   = ~tail_v_ff;
               state_in       = tail_v_ff ? ST_TAIL : ST_IDLE;
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               res_valid      = 1'b1;
               res.token_kind = tail_k_ff;
               res.token_last = 1'b1;
               res.run_last   = 1'b1;
               tail_v_in      = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mode_ff   <= MODE_IDLE;
         kept_ff   <= '0;
         rd_ok_ff  <= 1'b0;
         tail_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         kept_ff   <= kept_in;
         rd_ok_ff  <= rd_ok_in;
         tail_v_ff <= tail_v_in;
      end
   end

   always_ff @(posedge clock) begin
      flen_ff   <= flen_in;
      idx_ff    <= idx_in;
      tail_k_ff <= tail_k_in;
   end

   a_kept_cap: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= CAP_C)
      else $error("identifier count beyond buffer size");

   a_kept_mode: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_IDENT) |-> (kept_ff == '0))
      else $error("characters kept outside an identifier");

   a_flush_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (idx_ff < flen_ff))
      else $error("flush index past identifier length");

   a_end_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && is_eoi) |=> (mode_ff == MODE_IDLE && kept_ff == '0))
      else $error("end of input did not restart the lexer");

   a_res_free: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("result produced while output stage is full");

endmodule

>>> hw/rtl/spec_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// spec_token_lexer_unit
// Byte-serial tokenizer for a small specification language.
// ----------------------------------------------------------------------------
//
//   channel | direction | transfer carries
//   --------+-----------+---------------------------------------------------
//   req_*   | in        | one source byte, tlast or a NUL byte marks end of source
//   rsp_*   | out       | one token result (identifiers: one per character)
//
// A byte that yields a single token needs the transfer, then the result
// entering the output register. An identifier flush first reads the text
// buffer, then sends one kept character per cycle while the output register
// is free, paced by the single registered read port. Reset clears the lexer
// mode and the kept count; the text buffer is not cleared, since only written
// entries are ever read. A stalled rsp_ side holds the result in the output
// register while the sequencer waits.
//
module spec_token_lexer_unit #(
   parameter int NAME_BYTES = spec_tlx_pkg::NAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // is_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] text_byte, [12:8] char_index,
                                    // [17:13] ident_length, [23:18] zero
   output logic [4:0]  rsp_tuser,   // [3:0] token_kind, [4] token_last
   output logic        rsp_tlast    // run_last
);
   import spec_tlx_pkg::*;

   logic    out_free;
   logic    res_valid;
   res_type res;

   // Output register: one result waits here while the sequencer goes on.
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_res_ff, rsp_res_in;

   spec_tlx_seq #(
      .NAME_BYTES (NAME_BYTES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_byte  (req_tdata),
      .req_end   (req_tlast),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res)
   );

   // The register can take a new result when it is empty or being drained.
   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_res_in   = rsp_res_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_res_ff.ident_length, rsp_res_ff.char_index,
                        rsp_res_ff.text_byte};
   assign rsp_tuser  = {rsp_res_ff.token_last, rsp_res_ff.token_kind};
   assign rsp_tlast  = rsp_res_ff.run_last;

endmodule
